// ----- sv/dnf_pkg.sv -----
// Shared types, constants and register codes for the decimal number formatter.
`timescale 1ns / 1ps
package dnf_pkg;

   localparam int MaxDigits = 9;
   localparam int BcdDigits = 10;
   localparam int MagW      = 32;
   localparam int ConvSteps = MagW / 2;
   localparam int StepW     = $clog2(ConvSteps);
   localparam int TopW      = $clog2(BcdDigits + 1);
   localparam int CntW      = ($clog2(MaxDigits + 1) > 4) ? $clog2(MaxDigits + 1) : 4;
   localparam int LenW      = CntW + 1;
   localparam int PosW      = (MaxDigits > 1) ? $clog2(MaxDigits) : 1;
   localparam int QDepth    = 2;
   localparam int QPtrW     = $clog2(QDepth);
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 4;

   localparam logic [7:0] GlyphZero  = 8'd48;
   localparam logic [7:0] GlyphPoint = 8'd46;
   localparam logic [7:0] GlyphMinus = 8'd45;
   localparam logic [7:0] GlyphPlus  = 8'd43;
   localparam logic [3:0] NoPoint    = 4'd9;
   localparam logic [3:0] DigitMax   = 4'd9;

   localparam logic [CsrIdxW-1:0] CSR_DIGIT_COUNT    = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_POINT_POSITION = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_RIGHT_ALIGN    = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_SHOW_PLUS      = 2'd3;

   typedef logic [BcdDigits-1:0][3:0] bcd_type;

   typedef struct packed {
      logic signed [30:0] value;
      logic [1:0]         row;
      logic [5:0]         column;
   } req_type;

   typedef struct packed {
      logic [1:0]        out_row;
      logic signed [7:0] out_column;
      logic [7:0]        glyph;
      logic              last;
      logic [3:0]        width_used;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic [3:0] digit_count;
      logic [3:0] point_position;
      logic       right_align;
      logic       show_plus;
   } cfg_type;

   typedef struct packed {
      logic [MaxDigits-1:0][3:0] digits;
      logic [CntW-1:0]           count;
      logic                      neg;
      logic                      ovf;
      logic [1:0]                row;
      logic [5:0]                column;
   } rec_type;

endpackage

// ----- sv/dnf_front.sv -----
// Front end: accept a number, convert its magnitude to BCD, size the field.
`timescale 1ns / 1ps
module dnf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  dnf_pkg::req_type req_data,
   input  dnf_pkg::cfg_type cfg,
   output logic             q_push,
   output dnf_pkg::rec_type q_data,
   input  logic             q_full
);
   import dnf_pkg::*;

   localparam logic [1:0] FS_IDLE = 2'd0;
   localparam logic [1:0] FS_CONV = 2'd1;
   localparam logic [1:0] FS_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [StepW-1:0] step_ff, step_in;
   logic [MagW-1:0]  bin_ff, bin_in;
   bcd_type          bcd_ff, bcd_in;
   logic             neg_ff, neg_in;
   logic [1:0]       row_ff, row_in;
   logic [5:0]       col_ff, col_in;

   logic [30:0]               raw;
   logic [MagW-1:0]           mag;
   logic                      accept;
   logic [TopW-1:0]           top;
   logic [CntW-1:0]           cnt;
   logic                      ovf;
   logic [MaxDigits-1:0][3:0] digs;

   function automatic bcd_type dabble(input bcd_type b, input logic bin_in_bit);
      bcd_type              adj;
      logic [BcdDigits*4:0] wide;
      for (int p = 0; p < BcdDigits; p++) begin
         adj[p] = (b[p] >= 4'd5) ? b[p] + 4'd3 : b[p];
      end
      wide = {adj, bin_in_bit};
      return wide[BcdDigits*4-1:0];
   endfunction

   assign raw      = req_data.value;
   assign accept   = req_push && !req_full;
   assign req_full = state_ff != FS_IDLE;
   assign mag      = raw[30] ? (32'h8000_0000 - {1'b0, raw}) : {1'b0, raw};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               state_in = FS_CONV;
               step_in  = '0;
               bin_in   = mag;
               bcd_in   = '0;
               neg_in   = raw[30];
               row_in   = req_data.row;
               col_in   = req_data.column;
            end
         end
         FS_CONV: begin
            bcd_in  = dabble(dabble(bcd_ff, bin_ff[MagW-1]), bin_ff[MagW-2]);
            bin_in  = {bin_ff[MagW-3:0], 2'b00};
            step_in = step_ff + StepW'(1);
            if (step_ff == StepW'(ConvSteps - 1)) begin
               state_in = FS_DONE;
            end
         end
         FS_DONE: begin
            if (!q_full) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_comb begin
      top = '0;
      for (int p = 0; p < BcdDigits; p++) begin
         if (bcd_ff[p] != 4'd0) top = TopW'(p + 1);
      end
      if (cfg.digit_count == 4'd0) begin
         if (top == '0) cnt = CntW'(1);
         else if (int'(top) > MaxDigits) cnt = CntW'(MaxDigits);
         else cnt = CntW'(top);
      end else if (int'(cfg.digit_count) > MaxDigits) begin
         cnt = CntW'(MaxDigits);
      end else begin
         cnt = CntW'(cfg.digit_count);
      end
      ovf = 1'b0;
      for (int p = 0; p < BcdDigits; p++) begin
         if (p >= int'(cnt) && bcd_ff[p] != 4'd0) ovf = 1'b1;
      end
      for (int p = 0; p < MaxDigits; p++) begin
         digs[p] = (p < BcdDigits) ? bcd_ff[p % BcdDigits] : 4'd0;
         if (ovf && p == int'(cnt) - 1) digs[p] = DigitMax;
      end
   end

   assign q_push        = (state_ff == FS_DONE) && !q_full;
   assign q_data.digits = digs;
   assign q_data.count  = cnt;
   assign q_data.neg    = neg_ff;
   assign q_data.ovf    = ovf;
   assign q_data.row    = row_ff;
   assign q_data.column = col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      row_ff <= row_in;
      col_ff <= col_in;
   end

endmodule

// ----- sv/dnf_queue.sv -----
// Short queue of converted numbers between front and back end.
`timescale 1ns / 1ps
module dnf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dnf_pkg::rec_type push_data,
   output logic             full,
   input  logic             pop,
   output dnf_pkg::rec_type head,
   output logic             empty
);
   import dnf_pkg::*;

   rec_type            entry_ff [QDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPtrW:0]     count_ff, count_in;

   assign full  = count_ff == (QPtrW + 1)'(QDepth);
   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + (QPtrW + 1)'(1);
      else if (pop && !push) count_in = count_ff - (QPtrW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/dnf_back.sv -----
// Back end: walk one converted number and emit its character placements.
`timescale 1ns / 1ps
module dnf_back (
   input  logic             clock,
   input  logic             reset,
   input  dnf_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  dnf_pkg::rec_type q_head,
   output logic             q_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output dnf_pkg::rsp_type rsp_data
);
   import dnf_pkg::*;

   logic [LenW-1:0] idx_ff, idx_in;
   logic            valid_ff, valid_in;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;

   logic            has_sign;
   logic            pt_cfg;
   logic            pt_emit;
   logic [LenW-1:0] len;
   logic [LenW-1:0] seq_idx;
   logic [LenW-1:0] dig_idx;
   logic [LenW-1:0] pt_idx;
   logic [LenW-1:0] pos;
   logic [7:0]      col8;
   logic [7:0]      step8;
   logic            is_last;
   logic            out_free;
   logic            emit;

   assign has_sign = q_head.neg | (cfg.show_plus & ~cfg.right_align);
   assign pt_cfg   = cfg.point_position < NoPoint;
   assign pt_emit  = pt_cfg && (CntW'(cfg.point_position) < q_head.count);
   assign len      = LenW'(has_sign) + LenW'(q_head.count) + LenW'(pt_emit);
   assign seq_idx  = cfg.right_align ? len - LenW'(1) - idx_ff : idx_ff;
   assign dig_idx  = seq_idx - LenW'(has_sign);
   assign pt_idx   = LenW'(q_head.count) - LenW'(cfg.point_position);
   assign is_last  = idx_ff == len - LenW'(1);
   assign col8     = {2'b00, q_head.column};
   assign step8    = 8'(idx_ff);
   assign out_free = !valid_ff || rsp_pop;
   assign emit     = !q_empty && out_free;
   assign q_pop    = emit && is_last;

   always_comb begin
      pos = LenW'(q_head.count) - LenW'(1) - dig_idx;
      if (pt_emit && dig_idx > pt_idx) pos = LenW'(q_head.count) - dig_idx;
      rsp_in.out_row    = q_head.row;
      rsp_in.out_column = cfg.right_align ? col8 - step8 : col8 + step8;
      rsp_in.last       = is_last;
      rsp_in.width_used = 4'(q_head.count + CntW'(pt_cfg));
      rsp_in.overflow   = q_head.ovf;
      if (has_sign && seq_idx == '0) begin
         rsp_in.glyph = q_head.neg ? GlyphMinus : GlyphPlus;
      end else if (pt_emit && dig_idx == pt_idx) begin
         rsp_in.glyph = GlyphPoint;
      end else begin
         rsp_in.glyph = GlyphZero + {4'd0, q_head.digits[pos[PosW-1:0]]};
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (emit) begin
         idx_in   = is_last ? '0 : idx_ff + LenW'(1);
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- sv/decimal_number_formatter_core.sv -----
// Top level of the decimal number formatter: registers, front end, queue, back end.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------------------
//   request  | in        | req_push / req_full    | req_data (value, row, column)
//   response | out       | rsp_pop / rsp_empty    | rsp_data (one char placement)
//   csr      | in        | csr_we                 | csr_index, csr_wdata
//
// The front end loads a request, converts it from binary to BCD at two bits per
// cycle, then sizes the field and queues it. The back end emits one character
// per cycle while responses are taken, up to 11 per request, and works on the
// previous request while the front end converts the next one.
// Synchronous active-high reset clears control state and loads register defaults.
// A held response stalls the back end only; the front end stalls once the queue fills.
`timescale 1ns / 1ps
module decimal_number_formatter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  dnf_pkg::req_type                 req_data,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output dnf_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [dnf_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [dnf_pkg::CsrDataW-1:0]     csr_wdata
);
   import dnf_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    q_push;
   rec_type q_push_data;
   logic    q_full;
   logic    q_pop;
   rec_type q_head;
   logic    q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_DIGIT_COUNT:    cfg_in.digit_count    = csr_wdata;
            CSR_POINT_POSITION: cfg_in.point_position = csr_wdata;
            CSR_RIGHT_ALIGN:    cfg_in.right_align    = csr_wdata[0];
            CSR_SHOW_PLUS:      cfg_in.show_plus      = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.digit_count    <= 4'd0;
         cfg_ff.point_position <= NoPoint;
         cfg_ff.right_align    <= 1'b0;
         cfg_ff.show_plus      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dnf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_push   (q_push),
      .q_data   (q_push_data),
      .q_full   (q_full)
   );

   dnf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   dnf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/decimal_number_formatter_core_test.sv -----
// Self-checking testbench for the decimal number formatter core.
`timescale 1ns / 1ps
module decimal_number_formatter_core_test;
   import dnf_pkg::*;

   localparam int IdleLimit   = 4000;
   localparam int DrainCycles = 40;
   localparam int HoldCycles  = 400;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_push  = 1'b0;
   logic                req_full;
   req_type             req_data  = '0;
   logic                rsp_empty;
   logic                rsp_pop   = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_DIGIT_COUNT;
   logic [CsrDataW-1:0] csr_wdata = '0;

   cfg_type display_cfg = '{digit_count: 4'd0, point_position: NoPoint,
                            right_align: 1'b0, show_plus: 1'b0};
   rsp_type pending_chars[$];
   int      error_count  = 0;
   bit      no_gaps      = 1'b0;
   int      hold_request = 0;
   int      hold_served  = 0;
   int      pop_wait     = 0;
   int      idle_cycles  = 0;

   decimal_number_formatter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type make_req(input int value, input int row, input int column);
      req_type r;
      r.value  = value[30:0];
      r.row    = row[1:0];
      r.column = column[5:0];
      return r;
   endfunction

   function automatic int random_value();
      int lo;
      int mag;
      case ($urandom_range(0, 3))
         0: return int'($urandom);
         1: begin
            lo = 1;
            repeat ($urandom_range(0, 8)) lo *= 10;
            mag = lo + int'($urandom_range(0, 9 * lo - 1));
            return $urandom_range(0, 1) ? -mag : mag;
         end
         2: return int'($urandom_range(0, 20)) - 10;
         default: begin
            case ($urandom_range(0, 5))
               0: return 999999999;
               1: return -999999999;
               2: return 1000000000;
               3: return 1073741823;
               4: return -1073741824;
               default: return 0;
            endcase
         end
      endcase
   endfunction

   // Work out the character placements for one request under the current settings.
   function automatic void format_number(input req_type item);
      logic [30:0] raw;
      logic        neg;
      logic        ovf;
      logic        has_point;
      logic [31:0] mag;
      logic [31:0] q;
      logic [3:0]  digs[MaxDigits];
      logic [7:0]  chars[MaxDigits + 2];
      int          d;
      int          n;
      int          col;
      rsp_type     c;
      raw = item.value;
      neg = raw[30];
      mag = neg ? (32'h8000_0000 - {1'b0, raw}) : {1'b0, raw};
      if (display_cfg.digit_count == 0) begin
         d = 0;
         q = mag;
         do begin
            d++;
            q = q / 10;
         end while (q != 0);
         if (d > MaxDigits) d = MaxDigits;
      end else begin
         d = (display_cfg.digit_count > MaxDigits) ? MaxDigits : display_cfg.digit_count;
      end
      q = mag;
      for (int i = 0; i < d - 1; i++) begin
         digs[i] = 4'(q % 10);
         q = q / 10;
      end
      ovf = (q > 9);
      if (ovf) q = 9;
      digs[d - 1] = q[3:0];
      has_point = display_cfg.point_position < NoPoint;
      n = 0;
      if (neg) begin
         chars[n] = GlyphMinus;
         n++;
      end else if (display_cfg.show_plus && !display_cfg.right_align) begin
         chars[n] = GlyphPlus;
         n++;
      end
      for (int i = d; i > 0; i--) begin
         chars[n] = GlyphZero + 8'(digs[i - 1]);
         n++;
         if (has_point && (i - 1) == int'(display_cfg.point_position)) begin
            chars[n] = GlyphPoint;
            n++;
         end
      end
      for (int i = 0; i < n; i++) begin
         col            = display_cfg.right_align ? int'(item.column) - i : int'(item.column) + i;
         c.out_row      = item.row;
         c.out_column   = col[7:0];
         c.glyph        = display_cfg.right_align ? chars[n - 1 - i] : chars[i];
         c.last         = (i == n - 1);
         c.width_used   = 4'(d + (has_point ? 1 : 0));
         c.overflow     = ovf;
         pending_chars.push_back(c);
      end
   endfunction

   function automatic void check_char(input rsp_type got);
      rsp_type want;
      if (pending_chars.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("unexpected character: row %0d col %0d glyph %h last %0b width %0d ovf %0b",
                     got.out_row, got.out_column, got.glyph, got.last, got.width_used,
                     got.overflow);
         return;
      end
      want = pending_chars.pop_front();
      if (got.out_row !== want.out_row || got.out_column !== want.out_column ||
          got.glyph !== want.glyph || got.last !== want.last ||
          got.width_used !== want.width_used || got.overflow !== want.overflow) begin
         error_count++;
         if (error_count <= 10) begin
            $display("mismatch: expected row %0d col %0d glyph %h last %0b width %0d ovf %0b",
                     want.out_row, want.out_column, want.glyph, want.last, want.width_used,
                     want.overflow);
            $display("          actual   row %0d col %0d glyph %h last %0b width %0d ovf %0b",
                     got.out_row, got.out_column, got.glyph, got.last, got.width_used,
                     got.overflow);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_char(rsp_data);
         if (hold_request != hold_served) begin
            hold_served = hold_request;
            pop_wait    = HoldCycles;
         end
         if (pop_wait > 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            pop_wait = pick_gap();
            rsp_pop <= (pop_wait == 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("** decimal_number_formatter_core: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_number(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      format_number(item);
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_config(input logic [3:0] dc, input logic [3:0] pp,
                             input logic ra, input logic sp);
      csr_we    <= 1'b1;
      csr_index <= CSR_DIGIT_COUNT;
      csr_wdata <= dc;
      @(posedge clock);
      csr_index <= CSR_POINT_POSITION;
      csr_wdata <= pp;
      @(posedge clock);
      csr_index <= CSR_RIGHT_ALIGN;
      csr_wdata <= {3'b000, ra};
      @(posedge clock);
      csr_index <= CSR_SHOW_PLUS;
      csr_wdata <= {3'b000, sp};
      @(posedge clock);
      csr_we <= 1'b0;
      display_cfg = '{digit_count: dc, point_position: pp, right_align: ra, show_plus: sp};
   endtask

   task automatic test_reset_defaults();
      send_number(make_req(0, 0, 0));
      send_number(make_req(7, 3, 63));
      send_number(make_req(-7, 1, 20));
      send_number(make_req(1234, 2, 5));
      send_number(make_req(999999999, 0, 40));
      send_number(make_req(-999999999, 3, 0));
      send_number(make_req(1073741823, 1, 63));
      send_number(make_req(-1073741824, 2, 30));
   endtask

   task automatic test_field_modes();
      wait_idle();
      set_config(4'd5, 4'd2, 1'b0, 1'b1);
      send_number(make_req(42, 1, 10));
      send_number(make_req(-42, 2, 5));
      wait_idle();
      set_config(4'd3, 4'd0, 1'b0, 1'b0);
      send_number(make_req(12345, 0, 12));
      wait_idle();
      set_config(4'd2, 4'd5, 1'b1, 1'b1);
      send_number(make_req(7, 3, 0));
      wait_idle();
      set_config(4'd15, 4'd15, 1'b1, 1'b0);
      send_number(make_req(-123456789, 1, 3));
      wait_idle();
      set_config(4'd9, 4'd8, 1'b0, 1'b1);
      send_number(make_req(1073741823, 2, 63));
      wait_idle();
      set_config(4'd0, 4'd0, 1'b1, 1'b0);
      send_number(make_req(-1073741824, 0, 2));
      wait_idle();
      set_config(4'd1, NoPoint, 1'b0, 1'b0);
      send_number(make_req(0, 3, 33));
      send_number(make_req(10, 0, 60));
   endtask

   task automatic test_random_settings();
      logic [3:0] dc;
      logic [3:0] pp;
      for (int phase = 0; phase < 20; phase++) begin
         wait_idle();
         case (phase)
            0: set_config(4'd0, 4'd0, 1'b0, 1'b1);
            1: set_config(4'd9, 4'd8, 1'b1, 1'b0);
            2: set_config(4'd15, 4'd15, 1'b1, 1'b1);
            3: set_config(4'd1, NoPoint, 1'b0, 1'b0);
            default: begin
               dc = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
               pp = $urandom_range(0, 1) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(0, 15));
               set_config(dc, pp, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         endcase
         no_gaps = (phase % 5 == 3);
         repeat (20)
            send_number(make_req(random_value(), int'($urandom_range(0, 3)),
                                 int'($urandom_range(0, 63))));
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_backpressure();
      wait_idle();
      set_config(4'd0, 4'd1, 1'b0, 1'b1);
      no_gaps = 1'b1;
      hold_request++;
      repeat (24)
         send_number(make_req(random_value(), int'($urandom_range(0, 3)),
                              int'($urandom_range(0, 63))));
      no_gaps = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_field_modes();
      test_random_settings();
      test_backpressure();
      wait_idle();
      if (error_count == 0 && pending_chars.size() == 0)
         $display("** decimal_number_formatter_core: PASSED **");
      else
         $display("** decimal_number_formatter_core: FAILED **");
      $finish;
   end

endmodule
